// File: design/fcsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_pkg
// Shared widths, constants and controller/datapath interface types for the
// filled circle span generator.
// ----------------------------------------------------------------------------
package fcsg_pkg;

   localparam int COORD_WIDTH  = 12;
   localparam int SPAN_WIDTH   = COORD_WIDTH + 1;
   localparam int RADIUS_WIDTH = 4;
   localparam int MAX_RADIUS   = 15;
   localparam int OFFSET_WIDTH = 6;
   localparam int ERR_WIDTH    = 8;
   localparam int PHASE_WIDTH  = 2;

   // span phase codes, in emission order
   localparam logic [PHASE_WIDTH-1:0] PH_MAJOR_POS = 2'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_MAJOR_NEG = 2'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_MINOR_POS = 2'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_MINOR_NEG = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic load_circle;
      logic emit_span;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic radius_zero;
      logic slot_free;
      logic final_span;
   } dp_status_type;

   // sign extension of an offset to span width
   function automatic logic [SPAN_WIDTH-1:0] off_to_span(input logic [OFFSET_WIDTH-1:0] v);
      return {{(SPAN_WIDTH-OFFSET_WIDTH){v[OFFSET_WIDTH-1]}}, v};
   endfunction

   // sign extension of a coordinate to span width
   function automatic logic [SPAN_WIDTH-1:0] coord_to_span(input logic [COORD_WIDTH-1:0] v);
      return {{(SPAN_WIDTH-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
   endfunction

   // sign extension of an offset to error working width
   function automatic logic [ERR_WIDTH:0] off_to_err(input logic [OFFSET_WIDTH-1:0] v);
      return {{(ERR_WIDTH+1-OFFSET_WIDTH){v[OFFSET_WIDTH-1]}}, v};
   endfunction

endpackage

// File: design/filled_circle_span_generator.sv
`timescale 1ns / 1ps
// A transfer loads the recurrence registers; each span then enters the output register.
// Throughput: one span per cycle while the result side takes them; four spans per
// midpoint iteration, up to 40 spans for radius 15.
// The next circle is taken the cycle after the final span enters the output register;
// radius zero gives no spans and leaves the controller idle, ready for the next circle.
// Reset (synchronous, active high) returns the controller to idle and empties the output.
// ----------------------------------------------------------------------------
// filled_circle_span_generator
// Midpoint circle filled span generator: controller plus recurrence datapath.
// ----------------------------------------------------------------------------
module filled_circle_span_generator
   import fcsg_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_center_y,
   input  logic [RADIUS_WIDTH-1:0]       req_radius,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SPAN_WIDTH-1:0]  rsp_span_x_start,
   output logic signed [SPAN_WIDTH-1:0]  rsp_span_x_end,
   output logic signed [SPAN_WIDTH-1:0]  rsp_span_row,
   output logic                          rsp_last_span
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing
   fcsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // recurrence and span output
   fcsg_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_radius       (req_radius),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_span_x_start (rsp_span_x_start),
      .rsp_span_x_end   (rsp_span_x_end),
      .rsp_span_row     (rsp_span_row),
      .rsp_last_span    (rsp_last_span)
   );

endmodule

// File: design/fcsg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_ctrl
// Controller: accepts a circle when idle and steps the datapath through its
// spans, one per free output slot.
// ----------------------------------------------------------------------------
module fcsg_ctrl
   import fcsg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff;
   logic state_in;

   // handshake and commands
   always_comb begin
      req_ready       = (state_ff == ST_IDLE);
      cmd.load_circle = req_valid && req_ready;
      cmd.emit_span   = (state_ff == ST_RUN) && status.slot_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load_circle && !status.radius_zero) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cmd.emit_span && status.final_span) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_not_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.load_circle |-> !cmd.emit_span)
      else $error("circle load and span emit in the same cycle");

   a_final_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_span && status.final_span) |=> state_ff == ST_IDLE)
      else $error("controller did not return to idle after final span");

   a_zero_radius_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_circle && status.radius_zero) |=> state_ff == ST_IDLE)
      else $error("zero radius circle left the controller busy");

endmodule

// File: design/fcsg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_datapath
// Datapath: midpoint recurrence registers, span formation and the output
// register of the result channel.
// ----------------------------------------------------------------------------
module fcsg_datapath
   import fcsg_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [COORD_WIDTH-1:0] req_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_center_y,
   input  logic [RADIUS_WIDTH-1:0]      req_radius,
   input  dp_cmd_type                   cmd,
   output dp_status_type                status,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic signed [SPAN_WIDTH-1:0] rsp_span_x_start,
   output logic signed [SPAN_WIDTH-1:0] rsp_span_x_end,
   output logic signed [SPAN_WIDTH-1:0] rsp_span_row,
   output logic                         rsp_last_span
);

   logic signed [OFFSET_WIDTH-1:0] dx_ff, dx_in;
   logic signed [OFFSET_WIDTH-1:0] dy_ff, dy_in;
   logic signed [ERR_WIDTH-1:0]    err_ff, err_in;
   logic [COORD_WIDTH-1:0]         cx_ff, cx_in;
   logic [COORD_WIDTH-1:0]         cy_ff, cy_in;
   logic [PHASE_WIDTH-1:0]         phase_ff, phase_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [SPAN_WIDTH-1:0]          xs_ff, xs_in;
   logic [SPAN_WIDTH-1:0]          xe_ff, xe_in;
   logic [SPAN_WIDTH-1:0]          row_ff, row_in;
   logic                           last_ff, last_in;

   logic [RADIUS_WIDTH-1:0]        r_sat;
   logic signed [OFFSET_WIDTH-1:0] dx_init;
   logic signed [ERR_WIDTH-1:0]    err_init;

   logic signed [OFFSET_WIDTH-1:0] dy_step, dx_step;
   logic signed [ERR_WIDTH:0]      e_mid, e_end;

   logic [OFFSET_WIDTH-1:0]        half_w, vert_off;
   logic [SPAN_WIDTH-1:0]          cx_w, cy_w, half_s, vert_s;
   logic                           slot_free;
   logic                           iter_end;

   // start values of the recurrence
   always_comb begin
      r_sat    = (req_radius > RADIUS_WIDTH'(MAX_RADIUS)) ? RADIUS_WIDTH'(MAX_RADIUS)
                                                          : req_radius;
      dx_init  = OFFSET_WIDTH'(r_sat) - OFFSET_WIDTH'(1);
      err_init = ERR_WIDTH'(0) - ERR_WIDTH'(r_sat) - ERR_WIDTH'(1);
   end

   // one midpoint iteration: step minor, then major
   always_comb begin
      dy_step = dy_ff;
      dx_step = dx_ff;
      e_mid   = off_to_err(OFFSET_WIDTH'(0)) + {err_ff[ERR_WIDTH-1], err_ff};
      if (e_mid <= 0) begin
         dy_step = dy_ff + OFFSET_WIDTH'(1);
         e_mid   = e_mid + (off_to_err(dy_step) <<< 1) + (ERR_WIDTH+1)'(1);
      end
      e_end = e_mid;
      if (e_mid > 0) begin
         dx_step = dx_ff - OFFSET_WIDTH'(1);
         e_end   = e_mid - (off_to_err(dx_step) <<< 1) - (ERR_WIDTH+1)'(1);
      end
   end

   // span formation for the current phase
   always_comb begin
      half_w   = phase_ff[1] ? dy_ff : dx_ff;
      vert_off = phase_ff[1] ? dx_ff : dy_ff;
      cx_w     = coord_to_span(cx_ff);
      cy_w     = coord_to_span(cy_ff);
      half_s   = off_to_span(half_w);
      vert_s   = off_to_span(vert_off);
      xs_in    = cx_w - half_s;
      xe_in    = cx_w + half_s;
      row_in   = phase_ff[0] ? (cy_w - vert_s) : (cy_w + vert_s);
      iter_end = (phase_ff == PH_MINOR_NEG);
      last_in  = iter_end && (dx_step < dy_step);
   end

   // status to controller
   always_comb begin
      slot_free          = !rsp_valid_ff || rsp_ready;
      status.slot_free   = slot_free;
      status.radius_zero = (r_sat == '0);
      status.final_span  = last_in;
   end

   // recurrence state update
   always_comb begin
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      err_in   = err_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      phase_in = phase_ff;
      priority if (cmd.load_circle) begin
         dx_in    = dx_init;
         dy_in    = '0;
         err_in   = err_init;
         cx_in    = req_center_x;
         cy_in    = req_center_y;
         phase_in = PH_MAJOR_POS;
      end else if (cmd.emit_span) begin
         phase_in = phase_ff + PHASE_WIDTH'(1);
         if (iter_end) begin
            dx_in  = dx_step;
            dy_in  = dy_step;
            err_in = e_end[ERR_WIDTH-1:0];
         end
      end
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.emit_span) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dx_ff        <= '0;
         dy_ff        <= '0;
         err_ff       <= '0;
         cx_ff        <= '0;
         cy_ff        <= '0;
         phase_ff     <= PH_MAJOR_POS;
         rsp_valid_ff <= 1'b0;
      end else begin
         dx_ff        <= dx_in;
         dy_ff        <= dy_in;
         err_ff       <= err_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload, loaded on each transfer into the slot
   always_ff @(posedge clock) begin
      if (cmd.emit_span) begin
         xs_ff   <= xs_in;
         xe_ff   <= xe_in;
         row_ff  <= row_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_span_x_start = xs_ff;
   assign rsp_span_x_end   = xe_ff;
   assign rsp_span_row     = row_ff;
   assign rsp_last_span    = last_ff;

   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_span |-> slot_free)
      else $error("span emitted into an occupied output slot");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_span |=> rsp_valid_ff)
      else $error("output slot not valid after span emit");

   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=>
         (rsp_valid_ff && $stable({xs_ff, xe_ff, row_ff, last_ff})))
      else $error("waiting span changed or dropped before its transfer");

endmodule
